// ===== sv/vcs_pkg.sv =====
// shared constants of the versioned chunk suballocator
package vcs_pkg;
    localparam int MAX_CHUNKS_DEF   = 16;
    localparam int SIZE_BITS_DEF    = 32;
    localparam int VERSION_BITS_DEF = 48;
    localparam int POOL_BITS        = 37;
    localparam int ALIGN_BITS       = 16;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_NOSLOT = 2'd2;
    localparam logic [1:0] REG_DEFAULT = 2'd0;
    localparam logic [1:0] REG_LIMIT   = 2'd1;
    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_SUBMIT = 1'b1;
endpackage

// ===== sv/vcs_mod.sv =====
// iterative remainder unit: a % b, one quotient bit per cycle
module vcs_mod
    import vcs_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SIZE_BITS-1:0]   i_num,
    input  logic [ALIGN_BITS-1:0]  i_den,
    output logic                   o_done,
    output logic [ALIGN_BITS-1:0]  o_rem
);
    localparam int CW = $clog2(SIZE_BITS + 1);
    logic [SIZE_BITS-1:0]  r_num;
    logic [ALIGN_BITS:0]   r_rem;
    logic [ALIGN_BITS-1:0] r_den;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic [ALIGN_BITS:0]   w_sh;

    assign w_sh  = {r_rem[ALIGN_BITS-1:0], r_num[SIZE_BITS-1]};
    assign o_rem = r_rem[ALIGN_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SIZE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[SIZE_BITS-2:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) r_rem <= w_sh - {1'b0, r_den};
            else                       r_rem <= w_sh;
        end
    end
endmodule

// ===== sv/vcs_core.sv =====
// slot memory, pool fifo memory and the allocation sequencer
module vcs_core
    import vcs_pkg::*;
#(
    parameter int MAX_CHUNKS   = MAX_CHUNKS_DEF,
    parameter int SIZE_BITS    = SIZE_BITS_DEF,
    parameter int VERSION_BITS = VERSION_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [31:0]             i_default_size,
    input  logic [POOL_BITS-1:0]    i_limit,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_operation,
    input  logic [SIZE_BITS-1:0]    i_req_size,
    input  logic [ALIGN_BITS-1:0]   i_align,
    input  logic [VERSION_BITS-1:0] i_version,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_status,
    output logic [3:0]              o_chunk_slot,
    output logic [31:0]             o_offset,
    output logic                    o_new_chunk
);
    localparam int SW = $clog2(MAX_CHUNKS);
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int EW = 2 * SIZE_BITS + VERSION_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_RDCUR, S_LDCUR, S_MODGO, S_MODWAIT, S_FIT, S_PRD, S_PSEL, S_PCHK,
        S_SHRD, S_SHWR, S_NEW, S_SRD, S_SUB, S_EVCHK, S_EVSEL, S_EVSUB, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_CUR, PH_POOL, PH_NEW
    } t_phase;

    // slot memory: size, fill, version
    logic [EW-1:0] r_slot_mem [MAX_CHUNKS];
    logic [SW-1:0] r_pool_mem [MAX_CHUNKS];
    logic [EW-1:0] r_srd;
    logic [SW-1:0] r_prd;
    logic          s_we, p_we;
    logic [SW-1:0] s_wa, s_ra, p_wa, p_ra;
    logic [EW-1:0] s_wd;
    logic [SW-1:0] p_wd;

    always_ff @(posedge i_clk) begin
        if (s_we) r_slot_mem[s_wa] <= s_wd;
        r_srd <= r_slot_mem[s_ra];
    end
    always_ff @(posedge i_clk) begin
        if (p_we) r_pool_mem[p_wa] <= p_wd;
        r_prd <= r_pool_mem[p_ra];
    end

    logic [SIZE_BITS-1:0]    m_size, m_fill;
    logic [VERSION_BITS-1:0] m_ver;
    assign {m_size, m_fill, m_ver} = r_srd;

    t_state                  r_state;
    t_phase                  r_phase;
    logic                    r_evict;
    logic [MAX_CHUNKS-1:0]   r_live;
    logic [MAX_CHUNKS-1:0]   n_live;
    logic [CW-1:0]           r_pcnt;
    logic                    r_cvalid;
    logic [SW-1:0]           r_cslot;
    logic [POOL_BITS-1:0]    r_pbytes;
    logic [SIZE_BITS-1:0]    r_rsize, r_csize, r_cfill;
    logic [ALIGN_BITS-1:0]   r_align;
    logic [VERSION_BITS-1:0] r_ver, r_cver;
    logic [CW-1:0]           r_idx;
    logic [SW-1:0]           r_sel;
    logic [1:0]              r_rstat;
    logic [3:0]              r_rslot;
    logic [31:0]             r_roff;
    logic                    r_rnew;
    logic                    r_ovalid;
    logic [1:0]              r_ostat;
    logic [3:0]              r_oslot;
    logic [31:0]             r_ooff;
    logic                    r_onew;

    logic                    mod_start, mod_done;
    logic [ALIGN_BITS-1:0]   mod_rem;
    assign mod_start = (r_state == S_MODGO);
    vcs_mod #(.SIZE_BITS(SIZE_BITS)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mod_start),
        .i_num(r_cfill), .i_den(r_align), .o_done(mod_done), .o_rem(mod_rem)
    );

    // fit check; a pool or new chunk starts at fill zero, so its remainder is zero
    logic [ALIGN_BITS-1:0] w_rem;
    logic [SIZE_BITS:0]    f_pos;
    logic                  f_ok;
    logic [SIZE_BITS-1:0]  f_posn;
    logic [SIZE_BITS-1:0]  w_fill_new;
    assign w_rem = (r_phase == PH_CUR) ? mod_rem : '0;
    always_comb begin
        f_pos = {1'b0, r_cfill};
        if (r_align > ALIGN_BITS'(1) && w_rem != '0)
            f_pos = f_pos + (SIZE_BITS + 1)'(r_align - w_rem);
        f_posn = f_pos[SIZE_BITS-1:0];
        f_ok   = !f_pos[SIZE_BITS] && (f_posn <= r_csize) &&
                 (r_rsize <= r_csize - f_posn);
    end
    assign w_fill_new = f_ok ? (f_posn + r_rsize) : r_cfill;

    logic [SW-1:0] free_slot;
    logic          free_any;
    always_comb begin
        free_slot = '0;
        free_any  = 1'b0;
        for (int k = MAX_CHUNKS - 1; k >= 0; k--)
            if (!r_live[k]) begin
                free_slot = SW'(k);
                free_any  = 1'b1;
            end
    end

    logic [SW-1:0]        w_new_slot;
    logic [SIZE_BITS-1:0] w_def, w_new_size;
    logic                 w_new_ok, pool_hit;
    logic [CW-1:0]        w_idx_nx;
    assign w_new_slot = free_any ? free_slot : r_cslot;
    assign w_new_ok   = free_any || r_cvalid;
    assign w_def      = SIZE_BITS'(i_default_size);
    assign w_new_size = (r_rsize > w_def) ? r_rsize : w_def;
    assign pool_hit   = (m_size >= r_rsize) && (m_ver < r_ver);
    assign w_idx_nx   = r_idx + 1'b1;

    logic [POOL_BITS:0]   add_sum;
    logic [POOL_BITS-1:0] sub_res;
    assign add_sum = {1'b0, r_pbytes} + (POOL_BITS + 1)'(m_size);
    assign sub_res = (r_pbytes >= POOL_BITS'(m_size)) ? r_pbytes - POOL_BITS'(m_size) : '0;

    logic go;
    assign o_stall = (r_state != S_IDLE);
    assign go      = i_valid && !o_stall;

    always_comb begin
        n_live = r_live;
        if ((r_state == S_PCHK && pool_hit) || (r_state == S_NEW && w_new_ok)) begin
            if (r_cvalid) n_live[r_cslot] = 1'b0;
        end
        if (r_state == S_NEW && w_new_ok) n_live[w_new_slot] = 1'b1;
        if (r_state == S_EVSUB) n_live[r_sel] = 1'b0;
    end

    always_comb begin
        s_we = 1'b0; s_wa = r_sel; s_wd = {r_csize, w_fill_new, r_cver}; s_ra = r_sel;
        p_we = 1'b0; p_wa = r_idx[SW-1:0]; p_wd = r_prd; p_ra = r_idx[SW-1:0];
        unique case (r_state)
            S_RDCUR, S_SRD:  s_ra = r_cslot;
            S_PSEL, S_EVSEL: s_ra = r_prd;
            S_FIT:           s_we = 1'b1;
            S_SHRD:          p_ra = w_idx_nx[SW-1:0];
            S_SHWR:          p_we = 1'b1;
            S_SUB: begin
                // tag version, append to pool
                s_we = 1'b1; s_wa = r_cslot; s_wd = {m_size, m_fill, r_ver};
                p_we = 1'b1; p_wa = r_pcnt[SW-1:0]; p_wd = r_cslot;
            end
            S_EVCHK:         p_ra = '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_live <= '0; r_pcnt <= '0; r_cvalid <= 1'b0;
            r_cslot <= '0; r_pbytes <= '0; r_ovalid <= 1'b0;
        end else begin
            r_live <= n_live;
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall)                   r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (go) begin
                    r_rsize <= i_req_size; r_align <= i_align; r_ver <= i_version;
                    r_rstat <= ST_OK; r_rslot <= '0; r_roff <= '0; r_rnew <= 1'b0;
                    r_idx <= '0; r_sel <= r_cslot; r_phase <= PH_CUR; r_evict <= 1'b0;
                    if (i_operation == OP_SUBMIT) begin
                        if (r_cvalid && r_pcnt < CW'(MAX_CHUNKS)) r_state <= S_SRD;
                        else r_state <= S_OUT;
                    end else if (r_cvalid) r_state <= S_RDCUR;
                    else r_state <= S_PRD;
                end
                S_RDCUR: r_state <= S_LDCUR;
                S_LDCUR: begin
                    r_csize <= m_size; r_cfill <= m_fill; r_cver <= m_ver;
                    r_state <= S_MODGO;
                end
                S_MODGO: r_state <= S_MODWAIT;
                S_MODWAIT: if (mod_done) r_state <= S_FIT;
                S_FIT: begin
                    if (f_ok) begin
                        r_rslot <= 4'(r_sel); r_roff <= 32'(f_posn);
                        r_rnew <= (r_phase == PH_NEW); r_state <= S_OUT;
                    end else if (r_phase == PH_CUR) begin
                        r_state <= S_PRD;
                    end else begin
                        r_rstat <= ST_NOFIT; r_state <= S_OUT;
                    end
                end
                S_PRD: begin
                    if (r_idx >= r_pcnt) r_state <= S_NEW;
                    else r_state <= S_PSEL;
                end
                S_PSEL: begin r_sel <= r_prd; r_state <= S_PCHK; end
                S_PCHK: begin
                    if (pool_hit) begin
                        r_pbytes <= sub_res; r_csize <= m_size; r_cfill <= '0;
                        r_cver <= r_ver; r_cvalid <= 1'b1; r_cslot <= r_sel;
                        r_phase <= PH_POOL; r_state <= S_SHRD;
                    end else begin
                        r_idx <= w_idx_nx; r_state <= S_PRD;
                    end
                end
                // close the gap at r_idx, shifting each later entry down in S_SHRD then S_SHWR
                S_SHRD: begin
                    if (w_idx_nx >= r_pcnt) begin
                        r_pcnt <= r_pcnt - 1'b1;
                        r_state <= r_evict ? S_EVCHK : S_FIT;
                    end else r_state <= S_SHWR;
                end
                S_SHWR: begin r_idx <= w_idx_nx; r_state <= S_SHRD; end
                S_NEW: begin
                    if (w_new_ok) begin
                        r_csize <= w_new_size; r_cfill <= '0; r_cver <= r_ver;
                        r_cvalid <= 1'b1; r_cslot <= w_new_slot; r_sel <= w_new_slot;
                        r_phase <= PH_NEW; r_state <= S_FIT;
                    end else begin
                        r_rstat <= ST_NOSLOT; r_state <= S_OUT;
                    end
                end
                S_SRD: r_state <= S_SUB;
                S_SUB: begin
                    r_pbytes <= add_sum[POOL_BITS] ? '1 : add_sum[POOL_BITS-1:0];
                    r_pcnt <= r_pcnt + 1'b1; r_cvalid <= 1'b0;
                    r_rslot <= 4'(r_cslot); r_evict <= 1'b1; r_state <= S_EVCHK;
                end
                S_EVCHK: begin
                    if (i_limit != '0 && r_pbytes > i_limit && r_pcnt != '0)
                        r_state <= S_EVSEL;
                    else r_state <= S_OUT;
                end
                S_EVSEL: begin r_sel <= r_prd; r_state <= S_EVSUB; end
                S_EVSUB: begin r_pbytes <= sub_res; r_idx <= '0; r_state <= S_SHRD; end
                S_OUT: if (!r_ovalid || !i_stall) begin
                    r_ostat <= r_rstat; r_oslot <= r_rslot; r_ooff <= r_roff;
                    r_onew <= r_rnew; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_ostat;
    assign o_chunk_slot = r_oslot;
    assign o_offset     = r_ooff;
    assign o_new_chunk  = r_onew;
endmodule

// ===== sv/versioned_chunk_suballocator_top.sv =====
// top level: apb registers and the allocator core
// an allocate with a current chunk first runs one remainder pass of SIZE_BITS quotient bits;
// it may then walk the whole pool, and a submit may evict the whole pool
// one item at a time; a finished item waits in the output register while the next one runs
// synchronous active-low reset clears control state; slot memory needs no clearing
module versioned_chunk_suballocator_top
    import vcs_pkg::*;
#(
    parameter int MAX_CHUNKS   = MAX_CHUNKS_DEF,
    parameter int SIZE_BITS    = SIZE_BITS_DEF,
    parameter int VERSION_BITS = VERSION_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [63:0]             pwdata,
    output logic [63:0]             prdata,
    output logic                    pready,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_operation,
    input  logic [SIZE_BITS-1:0]    i_req_size,
    input  logic [ALIGN_BITS-1:0]   i_align,
    input  logic [VERSION_BITS-1:0] i_version,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_status,
    output logic [3:0]              o_chunk_slot,
    output logic [31:0]             o_offset,
    output logic                    o_new_chunk
);
    logic [31:0]          r_default;
    logic [POOL_BITS-1:0] r_limit;

    assign pready = 1'b1;
    // registers at 8-byte spacing since memory_limit is wider than 32 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= 32'd65536;
            r_limit   <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[3] == REG_DEFAULT[0]) r_default <= pwdata[31:0];
            else                             r_limit   <= pwdata[POOL_BITS-1:0];
        end
    end
    assign prdata = paddr[3] ? 64'(r_limit) : 64'(r_default);

    vcs_core #(
        .MAX_CHUNKS(MAX_CHUNKS), .SIZE_BITS(SIZE_BITS), .VERSION_BITS(VERSION_BITS)
    ) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_default_size(r_default), .i_limit(r_limit),
        .i_valid(i_valid), .o_stall(o_stall), .i_operation(i_operation),
        .i_req_size(i_req_size), .i_align(i_align), .i_version(i_version),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_chunk_slot(o_chunk_slot), .o_offset(o_offset), .o_new_chunk(o_new_chunk)
    );
endmodule
